>>> src/proper_divisor_sum_perfect_test_core_defines.svh
// Assertion macros for the proper divisor sum core.
// Each macro expects clk and rst to be visible where it is used.
`ifndef PROPER_DIVISOR_SUM_PERFECT_TEST_CORE_DEFINES_SVH
`define PROPER_DIVISOR_SUM_PERFECT_TEST_CORE_DEFINES_SVH

`ifndef SYNTH

// Check that cond_b holds in the same cycle as cond_a.
`define PDS_ASSERT_NOW(lbl, cond_a, cond_b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error(msg);

// Check that cond_b holds in the cycle after cond_a.
`define PDS_ASSERT_NEXT(lbl, cond_a, cond_b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error(msg);

`else

`define PDS_ASSERT_NOW(lbl, cond_a, cond_b, msg)
`define PDS_ASSERT_NEXT(lbl, cond_a, cond_b, msg)

`endif

`endif

>>> src/pds_pkg.sv
`default_nettype none

package pds_pkg;

  // Fixed field widths of the stream payloads.
  localparam int IN_W          = 32;
  localparam int TOTAL_W       = 36;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 40;
  localparam int NUM_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ADD_D,
    ST_ADD_Q,
    ST_FINISH
  } pds_state_t;

endpackage

`default_nettype wire

>>> src/proper_divisor_sum_perfect_test_core.sv
// Channel   Dir  Signals                          Payload
// s         in   s_tvalid s_tready s_tdata[31:0]  number
// m         out  m_tvalid m_tready m_tdata[39:0]  divisor_total
//                m_tuser                          perfect
//
// One request is worked at a time. With k = floor(sqrt(n)) - 1 candidate
// divisors (k = 0 for n below 4) and h of them dividing n, a request runs
// k rounds of check, division and divisor add, h quotient adds, then a
// last check and the finish step. The run time is set by the bit-serial
// restoring divider: one quotient bit per cycle, a full NUM_WIDTH-bit
// division per candidate. Reset (rst, synchronous) returns the control
// to idle and empties the output register; no clearing pass is needed.
// A result waits in the output register while m_tready is low; the next
// request is accepted and worked meanwhile and only its finish step holds.
`default_nettype none
`include "proper_divisor_sum_perfect_test_core_defines.svh"

module proper_divisor_sum_perfect_test_core #(
  parameter int NUM_WIDTH = pds_pkg::NUM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pds_pkg::IN_TDATA_W-1:0]   s_tdata,   // [31:0] number
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pds_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [35:0] divisor_total, [39:36] zero
  output logic                             m_tuser    // [0] perfect
);

  import pds_pkg::*;

  // Candidate divisor runs up to floor(sqrt(n)) + 1.
  localparam int D_W   = (NUM_WIDTH + 1) / 2 + 1;
  localparam int SQ_W  = 2 * D_W;
  // Proper divisor sum stays below 8n for n under 2^48.
  localparam int ACC_W = NUM_WIDTH + 3;
  localparam int CNT_W = $clog2(NUM_WIDTH);
  localparam int EXT_W = ACC_W + TOTAL_W;

  pds_state_t state, state_next;

  logic [NUM_WIDTH-1:0] num;       // number under test
  logic [NUM_WIDTH-1:0] num_sh;    // dividend shift line, MSB first
  logic [NUM_WIDTH-1:0] quo;       // quotient shift line
  logic [D_W-1:0]       rem;
  logic [D_W-1:0]       dvs;       // current candidate divisor
  logic [SQ_W-1:0]      dvs_sq;    // dvs * dvs, kept by increments
  logic [ACC_W-1:0]     acc;
  logic [CNT_W-1:0]     cnt;

  logic [IN_TDATA_W+NUM_WIDTH-1:0] in_ext;
  logic [NUM_WIDTH-1:0]            in_num;
  logic [D_W:0]                    rem_trial;
  logic                            rem_ge;
  logic [D_W:0]                    rem_diff;
  logic                            dvs_fits;
  logic [EXT_W-1:0]                acc_ext;
  logic                            acc_over;
  logic                            load_out;

  // Take the input modulo 2^NUM_WIDTH, extending when NUM_WIDTH is wider.
  assign in_ext = {{NUM_WIDTH{1'b0}}, s_tdata};
  assign in_num = in_ext[NUM_WIDTH-1:0];

  // One restoring division step: bring down the next dividend bit.
  assign rem_trial = {rem, num_sh[NUM_WIDTH-1]};
  assign rem_ge    = (rem_trial >= {1'b0, dvs});
  assign rem_diff  = rem_trial - {1'b0, dvs};

  assign dvs_fits = (dvs_sq <= SQ_W'(num));

  // Saturate the delivered total at 36 bits; the perfect test uses acc.
  assign acc_ext  = {{TOTAL_W{1'b0}}, acc};
  assign acc_over = |acc_ext[EXT_W-1:TOTAL_W];

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = dvs_fits ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_ADD_D;
      end
      ST_ADD_D: begin
        state_next = (rem == '0) ? ST_ADD_Q : ST_CHECK;
      end
      ST_ADD_Q: begin
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath: no reset needed, every request reloads it.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        num    <= in_num;
        acc    <= ACC_W'(in_num > NUM_WIDTH'(1));
        dvs    <= D_W'(2);
        dvs_sq <= SQ_W'(4);
      end
      ST_CHECK: begin
        num_sh <= num;
        rem    <= '0;
        cnt    <= CNT_W'(NUM_WIDTH - 1);
      end
      ST_DIV: begin
        num_sh <= {num_sh[NUM_WIDTH-2:0], 1'b0};
        quo    <= {quo[NUM_WIDTH-2:0], rem_ge};
        rem    <= rem_ge ? rem_diff[D_W-1:0] : rem_trial[D_W-1:0];
        cnt    <= cnt - CNT_W'(1);
      end
      ST_ADD_D: begin
        if (rem == '0) begin
          acc <= acc + ACC_W'(dvs);
        end else begin
          // Advance to the next candidate.
          dvs    <= dvs + D_W'(1);
          dvs_sq <= dvs_sq + SQ_W'({dvs, 1'b1});
        end
      end
      ST_ADD_Q: begin
        // Count an exact square root only once.
        if (quo != NUM_WIDTH'(dvs)) acc <= acc + ACC_W'(quo);
        dvs    <= dvs + D_W'(1);
        dvs_sq <= dvs_sq + SQ_W'({dvs, 1'b1});
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{(OUT_TDATA_W - TOTAL_W){1'b0}},
                  (acc_over ? {TOTAL_W{1'b1}} : acc_ext[TOTAL_W-1:0])};
      m_tuser <= (num != '0) && (acc == ACC_W'(num));
    end
  end

  `PDS_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state == ST_CHECK, "accept did not start")
  `PDS_ASSERT_NOW(a_rem_below_dvs, state == ST_DIV, rem < dvs, "remainder not below divisor")
  `PDS_ASSERT_NOW(a_square_tracks, state == ST_CHECK, dvs_sq == (SQ_W'(dvs) * SQ_W'(dvs)), "square out of step")
  `PDS_ASSERT_NOW(a_perfect_nonzero, m_tvalid && m_tuser, m_tdata[TOTAL_W-1:0] != '0, "perfect with zero total")

endmodule

`default_nettype wire
